[rtl/adsr_pkg.sv]
// Package for the blip envelope arpeggio block: types, codes, pitch table.
// No dependencies; used by every module in rtl/ except adsr_checker.
package adsr_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_IDX,
        ST_OUT
    } t_state;

    // Input commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_HOLD    = 3'd3;
    localparam logic [2:0] REG_RELEASE = 3'd4;
    localparam logic [2:0] REG_BDELAY  = 3'd5;
    localparam logic [2:0] REG_BPERIOD = 3'd6;
    localparam logic [2:0] REG_REPEAT  = 3'd7;

    localparam int unsigned NUM_SLOTS   = 3;
    localparam logic [14:0] ELAPSED_MAX = 15'h7FFF;
    localparam logic [5:0]  TICK_CAP    = 6'd32;
    // level numerator reaches 256*4095, so the divider needs 20 bits
    localparam int unsigned DIV_W       = 20;

    // Configuration registers
    typedef struct packed {
        logic [11:0] attack;
        logic [11:0] decay;
        logic [3:0]  sustain;
        logic [11:0] hold;
        logic [11:0] release_ms;
        logic [11:0] bdelay;
        logic [11:0] bperiod;
        logic        repeat_p;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch input beat, run setup
        logic div1_go;   // start level divide
        logic div2_go;   // start beat divide
        logic out_load;  // form result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } t_sts;

    // Tenths of hertz for each note, C up to B
    function automatic logic [12:0] tenths_hz(input logic [3:0] note);
        logic [12:0] v;
        begin
            unique case (note)
                4'd0:    v = 13'd2617;
                4'd1:    v = 13'd2772;
                4'd2:    v = 13'd2937;
                4'd3:    v = 13'd3112;
                4'd4:    v = 13'd3297;
                4'd5:    v = 13'd3493;
                4'd6:    v = 13'd3700;
                4'd7:    v = 13'd3920;
                4'd8:    v = 13'd4153;
                4'd9:    v = 13'd4400;
                4'd10:   v = 13'd4662;
                default: v = 13'd4939;
            endcase
            return v;
        end
    endfunction

    // Frequency in whole hertz: (tenths << octave) / 40, via reciprocal
    function automatic logic [9:0] freq_of(input logic [3:0] note, input logic [1:0] oct);
        logic [15:0] x;
        logic [31:0] p;
        logic [15:0] q;
        logic [15:0] r;
        begin
            x = 16'(tenths_hz(note)) << oct;
            p = 32'(x) * 32'd1638;          // just under 2^16/40, estimate never high
            q = p[31:16];
            r = x - 16'(q * 16'd40);
            if (r >= 16'd40) q = q + 16'd1;
            return q[9:0];
        end
    endfunction

endpackage

[rtl/adsr_blip_envelope_arpeggio.sv]
// Blip envelope generator with pitch arpeggio.
// Slave stream s_axis_* carries start/tick beats (tuser says which); master
// stream m_axis_* carries one result beat per input beat, tlast marks the
// beat on which a blip ends. APB port writes eight registers at 4*i.
// Each accepted beat runs through a setup step, two 20-step passes of one
// shared restoring divider (envelope level, pitch index) with a handoff
// step after each, then a step that loads the output register. One beat is
// worked at a time.
// Reset clears the timer, the running flag, stored count and duty, and all
// registers; pitch frequencies are undefined until a start writes them.
// A finished result waits in the output register; the next beat is taken
// while it waits, and its result loads when the register frees. While
// m_axis_tready is low the result holds, and a later result waits for it.
// Depends on adsr_pkg, adsr_ctrl, adsr_dp, adsr_div.
module adsr_blip_envelope_arpeggio #(
    parameter int MAX_PITCHES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tick_ms[8], wave_shape[2], pitch_count[2], note_a[4], octave_a[2],
    // note_b[4], octave_b[2], note_c[4], octave_c[2], zero pad[2]
    input  logic [31:0] s_axis_tdata,
    // cmd
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_on, pitch_hz[10], volume_level[8], pulse_duty[2],
    // remaining_ms[14], pitch_index[2], zero pad[3]
    output logic [39:0] m_axis_tdata,
    // blip_done
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    adsr_pkg::t_cfg r_cfg;
    adsr_pkg::t_cmd cmd;
    adsr_pkg::t_sts sts;
    logic [31:0] beat;
    logic [39:0] res_data;
    logic [1:0]  cap;
    logic        in_fire, out_fire;

    assign pready = 1'b1;
    assign cap = (MAX_PITCHES < 3) ? 2'(MAX_PITCHES) : 2'd3;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                adsr_pkg::REG_ATTACK:  r_cfg.attack     <= pwdata[11:0];
                adsr_pkg::REG_DECAY:   r_cfg.decay      <= pwdata[11:0];
                adsr_pkg::REG_SUSTAIN: r_cfg.sustain    <= pwdata[3:0];
                adsr_pkg::REG_HOLD:    r_cfg.hold       <= pwdata[11:0];
                adsr_pkg::REG_RELEASE: r_cfg.release_ms <= pwdata[11:0];
                adsr_pkg::REG_BDELAY:  r_cfg.bdelay     <= pwdata[11:0];
                adsr_pkg::REG_BPERIOD: r_cfg.bperiod    <= pwdata[11:0];
                default:               r_cfg.repeat_p   <= pwdata[0];
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[4:2])
            adsr_pkg::REG_ATTACK:  prdata = 32'(r_cfg.attack);
            adsr_pkg::REG_DECAY:   prdata = 32'(r_cfg.decay);
            adsr_pkg::REG_SUSTAIN: prdata = 32'(r_cfg.sustain);
            adsr_pkg::REG_HOLD:    prdata = 32'(r_cfg.hold);
            adsr_pkg::REG_RELEASE: prdata = 32'(r_cfg.release_ms);
            adsr_pkg::REG_BDELAY:  prdata = 32'(r_cfg.bdelay);
            adsr_pkg::REG_BPERIOD: prdata = 32'(r_cfg.bperiod);
            default:               prdata = 32'(r_cfg.repeat_p);
        endcase
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Internal beat layout: cmd in bit 0, then the tdata fields; pitch count capped
    always_comb begin
        beat = {1'b0, s_axis_tdata[29:0], s_axis_tuser};
        if (s_axis_tdata[11:10] > cap) beat[12:11] = cap;
    end

    adsr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_out_free(!m_axis_tvalid),
        .i_out_fire(out_fire),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_ready(s_axis_tready)
    );

    adsr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_beat     (beat),
        .i_out_fire (out_fire),
        .o_sts      (sts),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (res_data)
    );

    // Done flag rides on tlast, the rest stays in tdata
    assign m_axis_tdata = {3'b000, res_data[36:0]};
    assign m_axis_tlast = res_data[37];
endmodule

[rtl/adsr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on adsr_pkg.
module adsr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [adsr_pkg::DIV_W-1:0] i_num,
    input  logic [adsr_pkg::DIV_W-1:0] i_den,
    output logic                      o_busy,
    output logic [adsr_pkg::DIV_W-1:0] o_quo
);
    localparam int W  = adsr_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [W:0]    trial;

    // Load on go, else one shift-subtract step while busy
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_quo[W-1]};
        if (i_go) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = W'(trial - {1'b0, r_den});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CW'(1);
            n_busy = (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_go) r_den <= i_den;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

[rtl/adsr_ctrl.sv]
// Controller state machine: sequences setup, two divides and result.
// Depends on adsr_pkg.
module adsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_out_free,
    input  logic              i_out_fire,
    input  adsr_pkg::t_sts    i_sts,
    output adsr_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);
    adsr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= adsr_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            adsr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = adsr_pkg::ST_LOAD;
                end
            end
            adsr_pkg::ST_LOAD: begin
                o_cmd.div1_go = 1'b1;
                n_state       = adsr_pkg::ST_DIV;
            end
            adsr_pkg::ST_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div2_go = 1'b1;
                    n_state       = adsr_pkg::ST_IDX;
                end
            end
            adsr_pkg::ST_IDX: begin
                if (!i_sts.div_busy) n_state = adsr_pkg::ST_OUT;
            end
            adsr_pkg::ST_OUT: begin
                if (i_out_free || i_out_fire) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = adsr_pkg::ST_IDLE;
                end
            end
            default: n_state = adsr_pkg::ST_IDLE;
        endcase
    end
endmodule

[rtl/adsr_dp.sv]
// Datapath: timer, pitch store, envelope phase math, index, output register.
// Depends on adsr_pkg and adsr_div.
module adsr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adsr_pkg::t_cfg    i_cfg,
    input  adsr_pkg::t_cmd    i_cmd,
    input  logic [31:0]       i_beat,
    input  logic              i_out_fire,
    output adsr_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output logic [39:0]       o_out_data
);
    localparam int W = adsr_pkg::DIV_W;

    logic [14:0] r_elapsed;
    logic        r_run;
    logic [9:0]  r_freq [adsr_pkg::NUM_SLOTS];
    logic [1:0]  r_count;
    logic [1:0]  r_duty;

    // latched item and setup results
    logic        r_start;
    logic        r_done;
    logic        r_idle;
    logic [14:0] r_t;
    logic [2:0]  r_phase;
    logic        r_pos;
    logic [W-1:0] r_lvl_fix;
    logic [W-1:0] r_num, r_den;
    logic [W-1:0] r_bnum;
    logic [W-1:0] r_lvl;

    logic        div_busy;
    logic [W-1:0] div_quo;
    logic        div_go;
    logic [W-1:0] div_num, div_den;

    // input fields
    logic       b_cmd;
    logic [7:0] b_tick;
    logic [1:0] b_shape, b_pc;
    logic [3:0] b_na, b_nb, b_nc;
    logic [1:0] b_oa, b_ob, b_oc;
    assign b_cmd   = i_beat[0];
    assign b_tick  = i_beat[8:1];
    assign b_shape = i_beat[10:9];
    assign b_pc    = i_beat[12:11];
    assign b_na    = i_beat[16:13];
    assign b_oa    = i_beat[18:17];
    assign b_nb    = i_beat[22:19];
    assign b_ob    = i_beat[24:23];
    assign b_nc    = i_beat[28:25];
    assign b_oc    = i_beat[30:29];

    logic [13:0] total;
    logic [12:0] ad;
    logic [13:0] adh;
    assign ad    = 13'(i_cfg.attack) + 13'(i_cfg.decay);
    assign adh   = 14'(ad) + 14'(i_cfg.hold);
    assign total = adh + 14'(i_cfg.release_ms);

    // setup of tick math
    logic [5:0]  dt;
    logic [15:0] tsum;
    logic [14:0] tn;
    logic [14:0] u;
    logic [4:0]  sm10;
    logic [17:0] dnum;
    logic [17:0] dsub;
    logic [16:0] rnum;
    logic [1:0]  pc_cap;
    logic [3:0]  n_note_a, n_note_b, n_note_c;
    always_comb begin
        dt   = (b_tick > 8'(adsr_pkg::TICK_CAP)) ? adsr_pkg::TICK_CAP : b_tick[5:0];
        tsum = 16'(r_elapsed) + 16'(dt);
        tn   = (tsum > 16'(adsr_pkg::ELAPSED_MAX)) ? adsr_pkg::ELAPSED_MAX : tsum[14:0];
        u    = '0;
        sm10 = '0;
        dnum = '0;
        dsub = '0;
        rnum = '0;
        if (tn >= 15'(i_cfg.attack) && tn < 15'(ad)) u = tn - 15'(i_cfg.attack);
        else if (tn >= 15'(adh)) u = tn - 15'(adh);
        // decay numerator: 10*decay - (10 - s)*u
        if (i_cfg.sustain <= 4'd10) begin
            sm10 = 5'(4'd10 - i_cfg.sustain);
            dsub = 18'(sm10) * 18'(u);
            dnum = 18'(i_cfg.decay) * 18'd10;
            dnum = (dsub >= dnum) ? 18'd0 : dnum - dsub;
        end else begin
            sm10 = 5'(i_cfg.sustain - 4'd10);
            dnum = 18'(i_cfg.decay) * 18'd10 + 18'(sm10) * 18'(u);
        end
        rnum = (u >= 15'(i_cfg.release_ms)) ? 17'd0
             : 17'(i_cfg.sustain) * 17'(15'(i_cfg.release_ms) - u);
        pc_cap = b_pc;
        n_note_a = b_na; n_note_b = b_nb; n_note_c = b_nc;
    end

    // phase codes held in r_phase
    localparam logic [2:0] PH_ATT = 3'd0;
    localparam logic [2:0] PH_DEC = 3'd1;
    localparam logic [2:0] PH_HLD = 3'd2;
    localparam logic [2:0] PH_REL = 3'd3;

    // note above eleven reads as eleven
    function automatic logic [3:0] clamp_note(input logic [3:0] n);
        return (n > 4'd11) ? 4'd11 : n;
    endfunction

    // level numerator is value*17; kept within the divider by clamping to 256*den
    logic [21:0] anum17;
    logic [23:0] dnum17;
    logic [20:0] rnum17;
    assign anum17 = 22'd170 * 22'(tn);
    assign dnum17 = 24'(dnum) * 24'd17;
    assign rnum17 = 21'(rnum) * 21'd17;

    logic [W-1:0] set_num, set_den;
    logic [2:0]   set_ph;
    logic         set_pos;
    logic [W-1:0] set_fix;
    // level saturates at 255: a numerator at or above 256*den is replaced by
    // 256*den (below 2^20), the quotient then reads 256 and is clamped
    logic [23:0]  lim;
    always_comb begin
        set_ph  = PH_ATT;
        set_pos = 1'b0;
        set_fix = '0;
        set_num = '0;
        set_den = W'(1);
        if (tn < 15'(i_cfg.attack)) begin
            set_ph  = PH_ATT;
            set_pos = (tn != 15'd0);
            lim     = 24'(i_cfg.attack) << 8;
            set_den = W'(i_cfg.attack);
            set_num = (24'(anum17) >= lim) ? W'(lim) : W'(anum17);
        end else if (tn < 15'(ad)) begin
            set_ph  = PH_DEC;
            set_pos = (dnum != 18'd0);
            lim     = 24'(i_cfg.decay) << 8;
            set_den = W'(i_cfg.decay);
            set_num = (dnum17 >= lim) ? W'(lim) : W'(dnum17);
        end else if (tn < 15'(adh)) begin
            set_ph  = PH_HLD;
            set_pos = (i_cfg.sustain != 4'd0);
            set_fix = W'(i_cfg.sustain) * W'(17);
            lim     = '0;
        end else begin
            set_ph  = PH_REL;
            set_pos = (rnum != 17'd0);
            lim     = 24'(i_cfg.release_ms) << 8;
            set_den = W'(i_cfg.release_ms);
            set_num = (24'(rnum17) >= lim) ? W'(lim) : W'(rnum17);
        end
    end

    // Item latch and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_run     <= 1'b0;
            r_count   <= '0;
            r_duty    <= '0;
        end else if (i_cmd.load) begin
            if (b_cmd == adsr_pkg::CMD_START) begin
                r_duty    <= (b_shape == 2'd3) ? 2'd2 : b_shape;
                r_count   <= pc_cap;
                r_elapsed <= '0;
                r_run     <= 1'b1;
            end else if (r_run) begin
                r_elapsed <= tn;
                if (tn >= 15'(total)) r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start  <= (b_cmd == adsr_pkg::CMD_START);
            r_idle   <= (b_cmd == adsr_pkg::CMD_TICK) && !r_run;
            r_done   <= (b_cmd == adsr_pkg::CMD_TICK) && r_run && (tn >= 15'(total));
            r_t      <= tn;
            r_phase  <= set_ph;
            r_pos    <= set_pos;
            r_lvl_fix <= set_fix;
            r_num    <= set_num;
            r_den    <= set_den;
            r_bnum   <= (tn > 15'(i_cfg.bdelay)) ? W'(tn - 15'(i_cfg.bdelay)) : '0;
            if (b_cmd == adsr_pkg::CMD_START) begin
                if (pc_cap > 2'd0) r_freq[0] <= adsr_pkg::freq_of(clamp_note(n_note_a), b_oa);
                if (pc_cap > 2'd1) r_freq[1] <= adsr_pkg::freq_of(clamp_note(n_note_b), b_ob);
                if (pc_cap > 2'd2) r_freq[2] <= adsr_pkg::freq_of(clamp_note(n_note_c), b_oc);
            end
        end
        if (i_cmd.div2_go) r_lvl <= div_quo;
    end

    // Shared divider: level ratio first, then beat count
    assign div_go  = i_cmd.div1_go || i_cmd.div2_go;
    assign div_num = i_cmd.div2_go ? r_bnum : r_num;
    assign div_den = i_cmd.div2_go ? ((i_cfg.bperiod == 12'd0) ? W'(1) : W'(i_cfg.bperiod))
                                   : r_den;
    adsr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (div_go),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_quo  (div_quo)
    );
    assign o_sts.div_busy = div_busy;

    // Result assembly
    logic [7:0]   lvl;
    logic [1:0]   idx;
    logic [W-1:0] q;
    logic [30:0]  q3p;
    logic [14:0]  q3;
    logic [1:0]   qm;
    logic [9:0]   frq;
    logic [39:0]  res;
    always_comb begin
        q = div_quo;
        if (r_phase == PH_HLD) lvl = r_lvl_fix[7:0];
        else lvl = (r_lvl > W'(255)) ? 8'd255 : r_lvl[7:0];
        // q mod three by reciprocal: beat count is below 2^15, 21846 ~ 2^16/3
        q3p = 31'(q[14:0]) * 31'd21846;
        q3  = q3p[30:16];
        // q mod count, count at most three
        qm = '0;
        unique case (r_count)
            2'd1: qm = 2'd0;
            2'd2: qm = {1'b0, q[0]};
            2'd3: qm = 2'(q[14:0] - 15'(q3 * 15'd3));
            default: qm = 2'd0;
        endcase
        idx = '0;
        if (i_cfg.bperiod != 12'd0 && r_count != 2'd0) begin
            if (i_cfg.repeat_p) idx = qm;
            else idx = (q < W'(r_count - 2'd1)) ? q[1:0] : r_count - 2'd1;
        end
        frq = (r_count != 2'd0) ? r_freq[idx] : 10'd0;
        res = '0;
        if (r_start) begin
            res[0]     = (r_count != 2'd0);
            res[10:1]  = (r_count != 2'd0) ? r_freq[0] : 10'd0;
            res[20:19] = r_duty;
            res[34:21] = total;
        end else if (r_done) begin
            res[37] = 1'b1;
        end else if (!r_idle) begin
            res[0]     = r_pos && (r_count != 2'd0);
            res[10:1]  = frq;
            res[18:11] = lvl;
            res[20:19] = r_duty;
            res[34:21] = 14'(total - 14'(r_t));
            res[36:35] = idx;
        end
    end

    // Output register
    logic r_ovalid;
    logic [39:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (i_cmd.out_load) r_ovalid <= 1'b1;
        else if (i_out_fire) r_ovalid <= 1'b0;
        if (i_cmd.out_load) r_odata <= res;
    end
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule

[rtl/adsr_checker.sv]
// Port-level checker for the blip envelope block, bound to the top level.
// Depends on adsr_blip_envelope_arpeggio ports only.
module adsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    // result stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
    // a beat is not taken the cycle after another
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");
    // done result carries nothing else
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("done beat not clear");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind adsr_blip_envelope_arpeggio adsr_checker u_chk (.*);
